@@ design/pcnt_pkg.sv @@
package pcnt_pkg;

	// width of the tested value, sign bit included
	localparam int VALUE_WIDTH = 32;
	// width of the value field and count ports
	localparam int FIELD_W     = 32;
	localparam int COUNT_W     = 32;
	// magnitude bits once the sign is dropped
	localparam int MAG_W       = VALUE_WIDTH - 1;
	// divisor width: enough for the first divisor whose square passes the magnitude
	localparam int D_W         = (VALUE_WIDTH + 1) / 2 + 1;
	localparam int SQ_W        = 2 * D_W;
	// bit pointer for the remainder loop
	localparam int BIT_W       = (MAG_W > 1) ? $clog2(MAG_W) : 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [D_W-1:0]     D_FIRST   = D_W'(2);
	localparam logic [SQ_W-1:0]    SQ_FIRST  = SQ_W'(4);

	// controller to datapath
	typedef struct packed {
		logic load;       // capture an accepted item, reset divisor
		logic div_start;  // clear remainder, point at top magnitude bit
		logic div_step;   // one restoring remainder step
		logic next_d;     // advance divisor and its square
		logic finish;     // write the result register, update count
		logic prime;      // verdict that goes with finish
	} pcnt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic trivial;    // negative, zero or one
		logic sq_gt;      // divisor squared exceeds magnitude
		logic step_last;  // current step handles bit zero
		logic rem_zero;   // remainder of the finished pass is zero
		logic out_free;   // result register can take a new result
	} pcnt_sts_t;

endpackage

@@ design/prime_counter_core.sv @@
// steps: an item is accepted in idle and checked; negative values and values below 4
// go straight to done, otherwise each trial divisor takes a check, a remainder step per
// magnitude bit and an evaluation, up to about 46341 divisors for large primes
// one item at a time; in_stall is high until the current item's result is written
// a finished result sits in an output register, so a new item is taken while it waits
// reset: arst_n clears the controller, result valid and the running prime count
module prime_counter_core import pcnt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [FIELD_W-1:0] value,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      is_prime,
	output logic [COUNT_W-1:0]        prime_total,
	output logic                      set_end
);

	pcnt_cmd_t cmd;
	pcnt_sts_t sts;

	// sequencer
	pcnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// divisor, remainder and count datapath
	pcnt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_prime    (is_prime),
		.prime_total (prime_total),
		.set_end     (set_end)
	);

endmodule

@@ design/pcnt_dp.sv @@
module pcnt_dp import pcnt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pcnt_cmd_t                 cmd,
	output pcnt_sts_t                 sts,
	input  logic signed [FIELD_W-1:0] value,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      is_prime,
	output logic [COUNT_W-1:0]        prime_total,
	output logic                      set_end
);

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   last_q;
	logic [D_W-1:0]         d_q;
	logic [SQ_W-1:0]        d_sq_q;
	logic [D_W-1:0]         rem_q;
	logic [BIT_W-1:0]       bit_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   out_valid_q;
	logic                   is_prime_q;
	logic [COUNT_W-1:0]     total_q;
	logic                   set_end_q;

	logic [MAG_W-1:0]       mag;
	logic [D_W:0]           rem_sh;
	logic [D_W:0]           rem_nx;
	logic [COUNT_W-1:0]     count_nx;

	assign mag = value_q[MAG_W-1:0];

	// one restoring step: shift in next magnitude bit, subtract divisor if it fits
	always_comb begin
		rem_sh = {rem_q, mag[bit_q]};
		if (rem_sh >= {1'b0, d_q}) begin
			rem_nx = rem_sh - {1'b0, d_q};
		end else begin
			rem_nx = rem_sh;
		end
	end

	// saturating count including the current item
	always_comb begin
		if (cmd.prime && (count_q != COUNT_MAX)) begin
			count_nx = count_q + COUNT_W'(1);
		end else begin
			count_nx = count_q;
		end
	end

	// status back to the controller
	always_comb begin
		sts.trivial   = value_q[VALUE_WIDTH-1] || (mag <= MAG_W'(1));
		sts.sq_gt     = d_sq_q > SQ_W'(mag);
		sts.step_last = (bit_q == '0);
		sts.rem_zero  = (rem_q == '0);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// item capture and trial divisor
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value[VALUE_WIDTH-1:0];
			last_q  <= last;
			d_q     <= D_FIRST;
			d_sq_q  <= SQ_FIRST;
		end else if (cmd.next_d) begin
			d_q     <= d_q + D_W'(1);
			d_sq_q  <= d_sq_q + SQ_W'({d_q, 1'b0}) + SQ_W'(1);
		end
	end

	// remainder loop
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			bit_q <= BIT_W'(MAG_W - 1);
		end else if (cmd.div_step) begin
			rem_q <= rem_nx[D_W-1:0];
			bit_q <= bit_q - BIT_W'(1);
		end
	end

	// running count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				count_q     <= last_q ? '0 : count_nx;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			is_prime_q <= cmd.prime;
			total_q    <= count_nx;
			set_end_q  <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign is_prime    = is_prime_q;
	assign prime_total = total_q;
	assign set_end     = set_end_q;

endmodule

@@ design/pcnt_ctrl.sv @@
module pcnt_ctrl import pcnt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  pcnt_sts_t sts,
	output pcnt_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   prime_q;

	assign in_stall = (state_q != ST_IDLE);

	// commands decoded from state and status
	always_comb begin
		cmd = '0;
		cmd.prime = prime_q;
		unique case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_CHECK: cmd.div_start = !sts.trivial && !sts.sq_gt;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_EVAL:  cmd.next_d = !sts.rem_zero;
			ST_DONE:  cmd.finish = sts.out_free;
			default:  cmd = '0;
		endcase
	end

	// state and verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prime_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					priority if (sts.trivial) begin
						prime_q <= 1'b0;
						state_q <= ST_DONE;
					end else if (sts.sq_gt) begin
						prime_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.step_last) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (sts.rem_zero) begin
						prime_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ tb/sv/prime_counter_core_tb.sv @@
`timescale 1ns / 1ps

module prime_counter_core_tb;
	import pcnt_pkg::*;

	// run stops here even if results go missing; the limit lies far above what the
	// whole run needs, so no correct run reaches it
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DIRECTED_N  = 24;
	localparam int RANDOM_N    = 76;

	typedef struct packed {
		logic               is_prime;
		logic [COUNT_W-1:0] total;
		logic               set_end;
	} prime_res_t;

	typedef struct packed {
		logic [FIELD_W-1:0] v;
		logic               l;
		logic               typed;
		logic               exp_prime;
		logic [COUNT_W-1:0] exp_total;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [FIELD_W-1:0] value = '0;
	logic                      last = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      is_prime;
	logic [COUNT_W-1:0]        prime_total;
	logic                      set_end;

	// predictor state: primes counted so far in the current set
	logic [COUNT_W-1:0] set_primes = '0;
	prime_res_t         prime_results_due[$];
	int                 mismatches = 0;
	int                 cycles = 0;
	bit                 tx_calm = 1'b0;
	bit                 rx_calm = 1'b0;
	int                 rx_wait = 0;
	int                 rx_seen = 0;
	stim_row_t          dir_rows[DIRECTED_N];

	prime_counter_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_prime    (is_prime),
		.prime_total (prime_total),
		.set_end     (set_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL prime_counter_core");
				$finish;
			end
		end
	end

	// trial division on a non-negative magnitude, square taken wide
	function automatic logic trial_divide(input logic [63:0] mag);
		logic [63:0] d;
		if (mag <= 64'd1)
			return 1'b0;
		for (d = 64'd2; d * d <= mag; d++) begin
			if (mag % d == 64'd0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// next result of the block for one item, advances the set count
	function automatic prime_res_t predict_prime(input logic [FIELD_W-1:0] v, input logic l);
		logic [63:0] mask;
		logic [63:0] raw;
		logic        p;
		prime_res_t  r;
		mask = (64'd1 << VALUE_WIDTH) - 64'd1;
		raw  = 64'(v) & mask;
		p    = 1'b0;
		if (raw[VALUE_WIDTH-1] == 1'b0)
			p = trial_divide(raw);
		if (p && set_primes != COUNT_MAX)
			set_primes = set_primes + COUNT_W'(1);
		r.is_prime = p;
		r.total    = set_primes;
		r.set_end  = l;
		if (l)
			set_primes = '0;
		return r;
	endfunction

	// present one item, hold it until taken, then log what should come out
	task automatic send_item(input logic [FIELD_W-1:0] v, input logic l, input logic typed,
		input logic exp_prime, input logic [COUNT_W-1:0] exp_total);
		int         gap;
		prime_res_t r;
		gap = tx_calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		last     <= l;
		do @(posedge clk); while (in_stall);
		r = predict_prime(v, l);
		if (typed) begin
			r.is_prime = exp_prime;
			r.total    = exp_total;
		end
		prime_results_due.push_back(r);
	endtask

	// result side: check each taken result, then draw the next stall
	always @(posedge clk) begin
		prime_res_t want;
		if (out_valid && !out_stall) begin
			rx_seen++;
			if (rx_seen % 20 == 0)
				rx_calm = ~rx_calm;
			rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
			if (prime_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result is_prime=%0b total=%0d set_end=%0b",
					$time, is_prime, prime_total, set_end);
			end else begin
				want = prime_results_due.pop_front();
				if (is_prime !== want.is_prime) begin
					mismatches++;
					$display("%0t: is_prime expected %0b got %0b", $time, want.is_prime,
						is_prime);
				end
				if (prime_total !== want.total) begin
					mismatches++;
					$display("%0t: prime_total expected %0d got %0d", $time, want.total,
						prime_total);
				end
				if (set_end !== want.set_end) begin
					mismatches++;
					$display("%0t: set_end expected %0b got %0b", $time, want.set_end,
						set_end);
				end
			end
		end
		if (rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// stimulus
	initial begin
		int          sel;
		int          k;
		logic [31:0] v;
		logic        l;

		// value, last, typed, expected prime, expected count
		dir_rows = '{
			'{32'd0,          1'b0, 1'b1, 1'b0, 32'd0},   // zero right after reset
			'{32'd1,          1'b0, 1'b1, 1'b0, 32'd0},   // one is not prime
			'{32'd2,          1'b0, 1'b1, 1'b1, 32'd1},   // smallest prime
			'{32'd3,          1'b0, 1'b1, 1'b1, 32'd2},
			'{32'd4,          1'b0, 1'b1, 1'b0, 32'd2},
			'{32'hFFFF_FFFF,  1'b0, 1'b1, 1'b0, 32'd2},   // minus one
			'{32'h8000_0000,  1'b1, 1'b1, 1'b0, 32'd2},   // most negative, closes set
			'{32'd2,          1'b1, 1'b1, 1'b1, 32'd1},   // one-item set after clear
			'{32'h7FFF_FFFE,  1'b0, 1'b1, 1'b0, 32'd0},   // largest even value
			'{32'h7FFF_FFFD,  1'b0, 1'b1, 1'b0, 32'd0},   // multiple of five near top
			'{32'hFFFF_FFFE,  1'b0, 1'b1, 1'b0, 32'd0},   // minus two
			'{32'hFFFF_FFFD,  1'b0, 1'b1, 1'b0, 32'd0},   // minus three
			'{32'd9,          1'b0, 1'b0, 1'b0, 32'd0},   // square of a prime
			'{32'd25,         1'b0, 1'b0, 1'b0, 32'd0},
			'{32'd994009,     1'b0, 1'b0, 1'b0, 32'd0},   // 997 squared, last divisor hits
			'{32'd1000003,    1'b0, 1'b0, 1'b0, 32'd0},   // prime above a million
			'{32'd97,         1'b0, 1'b0, 1'b0, 32'd0},
			'{32'd5,          1'b1, 1'b0, 1'b0, 32'd0},
			'{32'd7919,       1'b0, 1'b0, 1'b0, 32'd0},
			'{32'd65537,      1'b0, 1'b0, 1'b0, 32'd0},
			'{32'd1000001,    1'b0, 1'b0, 1'b0, 32'd0},   // 101 times 9901
			'{32'h5555_5555,  1'b0, 1'b0, 1'b0, 32'd0},
			'{32'h2AAA_AAAA,  1'b0, 1'b0, 1'b0, 32'd0},
			'{32'd1,          1'b1, 1'b0, 1'b0, 32'd0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIRECTED_N; i++) begin
			if (i % 8 == 0)
				tx_calm = ~tx_calm;
			send_item(dir_rows[i].v, dir_rows[i].l, dir_rows[i].typed,
				dir_rows[i].exp_prime, dir_rows[i].exp_total);
		end

		// random sets, mostly small magnitudes so primes stay cheap;
		// large positives are forced composite with a small factor
		for (int i = 0; i < RANDOM_N; i++) begin
			if (i % 16 == 0)
				tx_calm = ($urandom_range(0, 2) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				v = $urandom_range(0, 2000);
			end else if (sel < 65) begin
				v = $urandom_range(2001, 100000);
			end else if (sel < 80) begin
				v = {1'b1, 31'($urandom)};
			end else if (sel < 92) begin
				v = $urandom_range(0, 32'h7FFF_FFFF);
				case ($urandom_range(0, 3))
					0: k = 2;
					1: k = 3;
					2: k = 5;
					default: k = 7;
				endcase
				v = v - (v % k);
			end else begin
				v = $urandom_range(0, 3);
			end
			l = ($urandom_range(0, 5) == 0) || (i == RANDOM_N - 1);
			send_item(v, l, 1'b0, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// drain, then a short quiet tail
		while (prime_results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("PASS prime_counter_core");
		else
			$display("FAIL prime_counter_core");
		$finish;
	end

endmodule

@@ files.f @@
design/pcnt_pkg.sv
design/pcnt_dp.sv
design/pcnt_ctrl.sv
design/prime_counter_core.sv
tb/sv/prime_counter_core_tb.sv
